@@ hw/rtl/bb3_pkg.sv @@
// Shared types, constants and the three-tap rounding function for the
// binomial blur block. Depends on nothing; every other RTL file imports it.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 12'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  // The depth must be a power of two so that the pointers wrap by themselves.
  localparam int JOB_FIFO_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_FIFO_DEPTH);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] h;
    logic             last_row;
    logic             last_step;
    logic             frame_end;
  } job_t;

  function automatic logic [PIX_W-1:0] taps3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    logic [PIX_W+1:0] sum;
    sum = (PIX_W+2)'(a) + ((PIX_W+2)'(b) << 1) + (PIX_W+2)'(c) + (PIX_W+2)'(2);
    return sum[PIX_W+1:2];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bb3_front.sv @@
// Front end of the blur: configuration registers, raster position counters and
// the horizontal filter. Turns each request into up to two column jobs. Uses bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_front
  import bb3_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [REG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PIX_W-1:0]       pixel_in,
  input  wire logic                   room_two,
  output logic                        push_first,
  output logic                        push_second,
  output job_t                        job_first,
  output job_t                        job_second
);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] prev_a;
  logic [PIX_W-1:0] prev_b;

  logic [CFG_W-1:0] width_eff;
  logic [CFG_W-1:0] height_eff;
  logic             accept;
  logic             row_end;
  logic             last_row;
  logic             has_left;
  logic [PIX_W-1:0] h_left;
  logic [PIX_W-1:0] h_edge;
  job_t             job_left;
  job_t             job_edge;

  always_comb begin
    if (image_width == '0) begin
      width_eff = CFG_W'(1);
    end else if (image_width > CFG_W'(MAX_WIDTH)) begin
      width_eff = CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height == '0) begin
      height_eff = CFG_W'(1);
    end else if (image_height > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign in_ready = room_two;
  assign accept   = in_valid && in_ready;
  assign row_end  = CFG_W'(column_count) >= (width_eff - CFG_W'(1));
  assign last_row = CFG_W'(row_count) >= (height_eff - CFG_W'(1));
  assign has_left = column_count != '0;

  assign h_left = taps3((column_count >= COL_W'(2)) ? prev_b : prev_a, prev_a, pixel_in);
  assign h_edge = taps3(has_left ? prev_a : pixel_in, pixel_in, pixel_in);

  always_comb begin
    job_left.col       = column_count - COL_W'(1);
    job_left.row       = row_count;
    job_left.h         = h_left;
    job_left.last_row  = last_row;
    job_left.last_step = !row_end;
    job_left.frame_end = 1'b0;

    job_edge.col       = column_count;
    job_edge.row       = row_count;
    job_edge.h         = h_edge;
    job_edge.last_row  = last_row;
    job_edge.last_step = 1'b1;
    job_edge.frame_end = last_row;
  end

  // The first slot always holds the earliest job of the request.
  assign job_first   = has_left ? job_left : job_edge;
  assign job_second  = job_edge;
  assign push_first  = accept && (has_left || row_end);
  assign push_second = accept && has_left && row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      prev_a       <= '0;
      prev_b       <= '0;
    end else if (accept) begin
      prev_b <= prev_a;
      prev_a <= pixel_in;
      if (row_end) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bb3_job_fifo.sv @@
// Short queue of column jobs between the horizontal front end and the vertical
// back end. Takes up to two jobs, gives one per cycle on pop_ready; uses bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_job_fifo
  import bb3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_first,
  input  wire logic push_second,
  input  wire job_t job_first,
  input  wire job_t job_second,
  output logic      room_two,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t                 entries [JOB_FIFO_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_PTR_W:0]   count;
  logic [JOB_PTR_W:0]   count_next;
  logic                 pop;

  assign pop_valid = count != '0;
  assign pop_job   = entries[rd_ptr];
  assign pop       = pop_valid && pop_ready;
  assign room_two  = count <= (JOB_PTR_W+1)'(JOB_FIFO_DEPTH - 2);

  always_comb begin
    count_next = count + (JOB_PTR_W+1)'(push_first) + (JOB_PTR_W+1)'(push_second)
                 - (JOB_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_first) begin
      entries[wr_ptr] <= job_first;
    end
    if (push_second) begin
      entries[wr_ptr + JOB_PTR_W'(1)] <= job_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + JOB_PTR_W'(push_first) + JOB_PTR_W'(push_second);
      if (pop) begin
        rd_ptr <= rd_ptr + JOB_PTR_W'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push_second |-> push_first)
    else $error("second job pushed without a first");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (JOB_PTR_W+1)'(JOB_FIFO_DEPTH))
    else $error("job queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    push_first |-> room_two)
    else $error("job pushed without room for two");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bb3_back.sv @@
// Back end of the blur: the two line stores, the vertical filter and the
// registered result stage. Uses bb3_pkg; fed by bb3_job_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bb3_back
  import bb3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire job_t              job_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       pixel_out,
  output logic [COL_W-1:0]       out_column,
  output logic [ROW_W-1:0]       out_row,
  output logic                   last_of_run,
  output logic                   end_of_frame
);

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  logic             b_valid;
  job_t             b_job;
  logic             b_phase;
  logic             b_fwd;
  logic [PIX_W-1:0] b_fwd_val;
  logic [PIX_W-1:0] rd_older;
  logic [PIX_W-1:0] rd_newer;

  logic             issue;
  logic             two_res;
  logic             any_res;
  logic             out_load;
  logic             emit;
  logic             res_last;
  logic             b_done;
  logic [PIX_W-1:0] top_eff;
  logic [PIX_W-1:0] mid_eff;
  logic [PIX_W-1:0] res_val;
  logic [ROW_W-1:0] res_row;
  logic [PIX_W-1:0] older_wdata;

  always_comb begin
    two_res  = (b_job.row != '0) && b_job.last_row;
    any_res  = (b_job.row != '0) || b_job.last_row;
    top_eff  = b_fwd ? b_fwd_val : rd_older;
    mid_eff  = rd_newer;
    res_last = !(two_res && !b_phase);
    out_load = !out_valid || out_ready;
    emit     = b_valid && any_res && out_load;
    b_done   = b_valid && (!any_res || (out_load && res_last));
    job_ready = !b_valid || b_done;
    issue    = job_valid && job_ready;

    if (b_job.row == '0) begin
      res_val = b_job.h;
      res_row = '0;
    end else if (b_phase) begin
      res_val = taps3(mid_eff, b_job.h, b_job.h);
      res_row = b_job.row;
    end else begin
      res_val = taps3(top_eff, mid_eff, b_job.h);
      res_row = b_job.row - ROW_W'(1);
    end

    older_wdata = (b_job.row == '0) ? b_job.h : mid_eff;
  end

  // The newer store takes a job's own value at issue; the older store takes
  // the shifted middle value (in row 0 the job's own value) when the job retires.
  always_ff @(posedge clk) begin
    if (issue) begin
      newer_mem[job_in.col] <= job_in.h;
      rd_newer              <= newer_mem[job_in.col];
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      older_mem[b_job.col] <= older_wdata;
    end
    if (issue) begin
      rd_older <= older_mem[job_in.col];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_job     <= job_in;
      b_fwd     <= b_done && (b_job.col == job_in.col);
      b_fwd_val <= older_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        b_phase <= 1'b0;
      end else if (emit) begin
        b_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_out    <= res_val;
      out_column   <= b_job.col;
      out_row      <= res_row;
      last_of_run  <= res_last && b_job.last_step;
      end_of_frame <= res_last && b_job.frame_end;
    end
  end

`ifndef SYNTHESIS
  a_phase_two_only: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_phase |-> (b_job.row != '0) && b_job.last_row)
    else $error("second result phase on a job with one result");

  a_phase_after_first: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_phase |-> out_valid)
    else $error("second result pending with an empty output stage");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_of_run)
    else $error("end of frame on a result that does not end its run");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/binomial_blur_3x3.sv @@
// Top level of the separable 3x3 binomial blur for 8-bit luma.
// Connects bb3_front, bb3_job_fifo and bb3_back; uses bb3_pkg.
//
//   channel  handshake                payload
//   config   cfg_write                cfg_index, cfg_data
//   input    in_valid / in_ready      pixel_in
//   output   out_valid / out_ready    pixel_out, out_column, out_row,
//                                     last_of_run, end_of_frame
//
// One pixel is taken per cycle while the queue has room for two jobs; a row-end
// pixel yields two column jobs and the first pixel of the next row yields none,
// so the back end keeps pace at one job per cycle unless the output stalls. In
// the last row of a frame taller than one row each job gives two results through
// the single result register, halving the rate there. Reset is synchronous and
// clears counters, pointers and valid flags; the line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binomial_blur_3x3
  import bb3_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [REG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PIX_W-1:0]       pixel_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PIX_W-1:0]            pixel_out,
  output logic [COL_W-1:0]            out_column,
  output logic [ROW_W-1:0]            out_row,
  output logic                        last_of_run,
  output logic                        end_of_frame
);

  logic room_two;
  logic push_first;
  logic push_second;
  job_t job_first;
  job_t job_second;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  bb3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_in    (pixel_in),
    .room_two    (room_two),
    .push_first  (push_first),
    .push_second (push_second),
    .job_first   (job_first),
    .job_second  (job_second)
  );

  bb3_job_fifo u_job_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_first  (push_first),
    .push_second (push_second),
    .job_first   (job_first),
    .job_second  (job_second),
    .room_two    (room_two),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job)
  );

  bb3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job_in       (pop_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .out_column   (out_column),
    .out_row      (out_row),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

endmodule

`default_nettype wire

@@ tb/blur_checker.sv @@
// Scoreboard for the 3x3 binomial blur: it follows the register writes and both
// channels, predicts every filtered pixel and compares each one as it arrives.
// Depends on bb3_pkg for the widths, the register indexes and the reset values.
`timescale 1ns / 1ps

module blur_checker
  import bb3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [PIX_W-1:0]       pixel_in,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [PIX_W-1:0]       pixel_out,
  input  logic [COL_W-1:0]       out_column,
  input  logic [ROW_W-1:0]       out_row,
  input  logic                   last_of_run,
  input  logic                   end_of_frame,
  output int                     fail_count,
  output int                     pending,
  output int                     next_row,
  output int                     pixels_checked,
  output int                     frames_seen
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             run_end;
    logic             frame_end;
  } blur_pixel_t;

  blur_pixel_t      expected_q[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               next_col;
  logic [PIX_W-1:0] prev_a;
  logic [PIX_W-1:0] prev_b;
  logic [PIX_W-1:0] older_row [MAX_WIDTH];
  logic [PIX_W-1:0] newer_row [MAX_WIDTH];

  function automatic logic [PIX_W-1:0] blur_tap(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
    logic [PIX_W+1:0] total;
    total = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
    return total[PIX_W+1:2];
  endfunction

  function automatic int fit_dim(input logic [CFG_W-1:0] v, input int limit);
    if (v == 0) begin
      return 1;
    end
    return (v > limit) ? limit : int'(v);
  endfunction

  task automatic add_result(input logic [PIX_W-1:0] pix, input int col, input int row);
    blur_pixel_t r;
    r.pixel = pix;
    r.column = col[COL_W-1:0];
    r.row = row[ROW_W-1:0];
    r.run_end = 1'b0;
    r.frame_end = 1'b0;
    expected_q.push_back(r);
  endtask

  // One horizontally filtered value for column c of the current row.
  task automatic vertical_tap(input int c, input bit last_row, input logic [PIX_W-1:0] h);
    logic [COL_W-1:0] ci;
    ci = c[COL_W-1:0];
    if (next_row == 0) begin
      if (last_row) begin
        add_result(h, c, 0);
      end
      older_row[ci] = h;
      newer_row[ci] = h;
    end else begin
      add_result(blur_tap(older_row[ci], newer_row[ci], h), c, next_row - 1);
      if (last_row) begin
        add_result(blur_tap(newer_row[ci], h, h), c, next_row);
      end
      older_row[ci] = newer_row[ci];
      newer_row[ci] = h;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    blur_pixel_t want;
    blur_pixel_t tail;
    int          w;
    int          hgt;
    int          first;
    bit          row_end;
    bit          last_row;
    logic [PIX_W-1:0] left;
    if (rst) begin
      width_reg = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      next_col = 0;
      next_row = 0;
      prev_a = '0;
      prev_b = '0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: width_reg = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual pixel %0d row %0d column %0d",
                   $time, pixel_out, out_row, out_column);
        end else begin
          want = expected_q.pop_front();
          check_field("pixel_out", 16'(want.pixel), 16'(pixel_out));
          check_field("out_column", 16'(want.column), 16'(out_column));
          check_field("out_row", 16'(want.row), 16'(out_row));
          check_field("last_of_run", 16'(want.run_end), 16'(last_of_run));
          check_field("end_of_frame", 16'(want.frame_end), 16'(end_of_frame));
        end
      end
      // Each accepted request is filtered horizontally, then fed to the column stores.
      if (in_valid && in_ready) begin
        w = fit_dim(width_reg, MAX_WIDTH);
        hgt = fit_dim(height_reg, MAX_HEIGHT);
        row_end = (next_col >= w - 1);
        last_row = (next_row >= hgt - 1);
        first = expected_q.size();
        if (next_col >= 1) begin
          left = (next_col > 1) ? prev_b : prev_a;
          vertical_tap(next_col - 1, last_row, blur_tap(left, prev_a, pixel_in));
        end
        if (row_end) begin
          left = (next_col >= 1) ? prev_a : pixel_in;
          vertical_tap(next_col, last_row, blur_tap(left, pixel_in, pixel_in));
        end
        if (expected_q.size() > first) begin
          tail = expected_q.pop_back();
          tail.run_end = 1'b1;
          tail.frame_end = row_end && last_row;
          expected_q.push_back(tail);
        end
        prev_b = prev_a;
        prev_a = pixel_in;
        if (row_end) begin
          next_col = 0;
          if (last_row) begin
            next_row = 0;
            frames_seen++;
          end else begin
            next_row++;
          end
        end else begin
          next_col++;
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the binomial blur testbench: clock, reset, register writes, pixel
// stimulus and output back pressure, with the verdict at the end.
// Depends on bb3_pkg, binomial_blur_3x3 and blur_checker.
`timescale 1ns / 1ps

module testbench;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_CYCLES = 120;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PIX_W-1:0]       pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIX_W-1:0]       pixel_out;
  logic [COL_W-1:0]       out_column;
  logic [ROW_W-1:0]       out_row;
  logic                   last_of_run;
  logic                   end_of_frame;

  int fail_count;
  int pending;
  int next_row;
  int pixels_checked;
  int frames_seen;

  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  bit               hold_req = 1'b0;
  bit               hold_ack = 1'b0;
  int               hold_left = 0;
  int               cycle_count = 0;
  int               pixels_sent = 0;
  int               settings_used = 0;
  logic [CFG_W-1:0] width_val = IMAGE_WIDTH_RESET;

  binomial_blur_3x3 DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .out_column(out_column),
    .out_row(out_row),
    .last_of_run(last_of_run),
    .end_of_frame(end_of_frame)
  );

  blur_checker blur_check (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .out_column(out_column),
    .out_row(out_row),
    .last_of_run(last_of_run),
    .end_of_frame(end_of_frame),
    .fail_count(fail_count),
    .pending(pending),
    .next_row(next_row),
    .pixels_checked(pixels_checked),
    .frames_seen(frames_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output back pressure, with an occasional long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The width may only grow while row 0 is under way, so that every column
  // read later in the frame has been written in it.
  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] w_used;
    drain();
    w_used = w;
    if (next_row != 0 && ((w == 0) ? 1 : w) > ((width_val == 0) ? 1 : width_val)) begin
      w_used = width_val;
    end
    width_val = w_used;
    settings_used++;
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w_used;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int count,
                           input bit long_hold);
    int               until_change;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    until_change = 0;
    for (int i = 0; i < count; i++) begin
      if (until_change == 0) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = CFG_W'($urandom_range(MAX_WIDTH + 1, 4095));
          default: w = CFG_W'($urandom_range(1, 10));
        endcase
        case ($urandom_range(0, 9))
          0: h = 0;
          1: h = 4095;
          default: h = CFG_W'($urandom_range(1, 6));
        endcase
        if (long_hold && i == 0) begin
          w = 5;
          h = 4;
        end
        configure(w, h);
        if (long_hold && i == 0) begin
          hold_req <= ~hold_req;
        end
        until_change = $urandom_range(12, 30);
      end
      until_change--;
      case ($urandom_range(0, 9))
        0: send_pixel(8'h00);
        1: send_pixel(8'hFF);
        default: send_pixel(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    configure(0, 0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    configure(3, 1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    configure(1, 3);
    send_pixel(8'h80);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    configure(4, 3);
    for (int i = 0; i < 12; i++) begin
      send_pixel(((i + i / 4) % 2) ? 8'hFF : 8'h00);
    end
    // Oversized registers, then both shrunk in the middle of the frame.
    configure(4095, 4095);
    repeat (3) send_pixel(PIX_W'($urandom_range(0, 255)));
    configure(2, 4095);
    send_pixel(8'h5A);
    configure(2, 0);
    send_pixel(8'hC3);
    send_pixel(8'h3C);

    run_phase(29, 50, 70, 1'b0);
    run_phase(50, 29, 70, 1'b0);
    run_phase(0, 0, 70, 1'b1);
    drain();

    $display("Sent %0d pixels under %0d register settings.", pixels_sent, settings_used);
    $display("Checked %0d filtered pixels over %0d completed frames.",
             pixels_checked, frames_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
